/* rtl/lcr_pkg.sv */
// Shared types and constants for the line cell rasterizer.
// No dependencies; the files that use it refer to this package by scoped names.
`timescale 1ns / 1ps

package lcr_pkg;

    // Spans and step indexes never exceed 63 cells.
    localparam int SPAN_BITS = 6;
    // Holds the rounding remainder plus one doubled minor step (at most 251).
    localparam int REM_BITS  = 8;

    // Classification of one line, produced by the front end.
    typedef struct packed {
        logic major_y;   // major axis is y
        logic maj_neg;   // major coordinate decreases
        logic min_neg;   // minor coordinate decreases
        logic too_long;  // span exceeds the step limit
    } line_flags_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

endpackage

/* rtl/lcr_front.sv */
// Front end of the line cell rasterizer: takes endpoint requests and classifies them.
// Depends on lcr_pkg for the flag struct and span width.
`timescale 1ns / 1ps

module lcr_front #(
    parameter int COORD_BITS = 10,
    parameter int MAX_STEPS  = 63
) (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [COORD_BITS-1:0]         start_x,
    input  logic [COORD_BITS-1:0]         start_y,
    input  logic [COORD_BITS-1:0]         end_x,
    input  logic [COORD_BITS-1:0]         end_y,
    input  logic                          queue_full,
    output logic                          push,
    output lcr_pkg::line_flags_t          flags,
    output logic [lcr_pkg::SPAN_BITS-1:0] span,
    output logic [lcr_pkg::SPAN_BITS-1:0] minor_span,
    output logic [COORD_BITS-1:0]         start_major,
    output logic [COORD_BITS-1:0]         start_minor
);

    localparam int EXT_W = (COORD_BITS > lcr_pkg::SPAN_BITS) ? COORD_BITS : lcr_pkg::SPAN_BITS;

    logic                  x_neg;
    logic                  y_neg;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic                  major_y;
    logic [EXT_W-1:0]      span_ext;
    logic [EXT_W-1:0]      minor_ext;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        x_neg     = end_x < start_x;
        y_neg     = end_y < start_y;
        abs_dx    = x_neg ? (start_x - end_x) : (end_x - start_x);
        abs_dy    = y_neg ? (start_y - end_y) : (end_y - start_y);
        // Ties between the axes go to x.
        major_y   = abs_dy > abs_dx;
        span_ext  = EXT_W'(major_y ? abs_dy : abs_dx);
        minor_ext = EXT_W'(major_y ? abs_dx : abs_dy);

        flags.major_y  = major_y;
        flags.maj_neg  = major_y ? y_neg : x_neg;
        flags.min_neg  = major_y ? x_neg : y_neg;
        flags.too_long = span_ext > EXT_W'(MAX_STEPS);

        span        = span_ext[lcr_pkg::SPAN_BITS-1:0];
        minor_span  = minor_ext[lcr_pkg::SPAN_BITS-1:0];
        start_major = major_y ? start_y : start_x;
        start_minor = major_y ? start_x : start_y;
    end

endmodule

/* rtl/lcr_queue.sv */
// Small register queue that decouples the front end from the stepping back end.
// Generic payload; no package dependencies.
`timescale 1ns / 1ps

module lcr_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/lcr_back.sv */
// Back end of the line cell rasterizer: steps the major axis, one cell per cycle while
// the output is free. Uses lcr_pkg for the flag struct, widths and the state enum.
`timescale 1ns / 1ps

module lcr_back #(
    parameter int COORD_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  lcr_pkg::line_flags_t          cmd_flags,
    input  logic [lcr_pkg::SPAN_BITS-1:0] cmd_span,
    input  logic [lcr_pkg::SPAN_BITS-1:0] cmd_minor_span,
    input  logic [COORD_BITS-1:0]         cmd_start_major,
    input  logic [COORD_BITS-1:0]         cmd_start_minor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_BITS-1:0]         point_x,
    output logic [COORD_BITS-1:0]         point_y,
    output logic                          last,
    output logic                          too_long
);

    localparam int SB = lcr_pkg::SPAN_BITS;
    localparam int RB = lcr_pkg::REM_BITS;

    lcr_pkg::back_state_t state_reg;
    lcr_pkg::back_state_t state_next;

    // Line held while stepping.
    lcr_pkg::line_flags_t  flags_reg;
    logic [SB-1:0]         span_reg;
    logic [RB-1:0]         two_minor_reg;
    logic [RB-1:0]         two_span_reg;
    logic [SB-1:0]         step_reg;
    logic [RB-1:0]         rem_reg;
    logic [COORD_BITS-1:0] major_reg;
    logic [COORD_BITS-1:0] minor_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] point_x_reg;
    logic [COORD_BITS-1:0] point_y_reg;
    logic                  last_reg;
    logic                  too_long_reg;

    logic                  out_free;
    logic                  load;
    logic                  advance;
    logic [SB-1:0]         step_adv;
    logic [RB-1:0]         rem_sum;
    logic                  minor_moves;
    logic [RB-1:0]         rem_adv;
    logic [COORD_BITS-1:0] major_adv;
    logic [COORD_BITS-1:0] minor_adv;
    logic                  last_adv;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign last      = last_reg;
    assign too_long  = too_long_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcr_pkg::ST_IDLE:
            begin
                if (load && !cmd_flags.too_long && (cmd_span != '0))
                begin
                    state_next = lcr_pkg::ST_RUN;
                end
            end
            lcr_pkg::ST_RUN:
            begin
                if (advance && last_adv)
                begin
                    state_next = lcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        load    = 1'b0;
        advance = 1'b0;
        unique case (state_reg)
            lcr_pkg::ST_IDLE: load    = !cmd_empty && out_free;
            lcr_pkg::ST_RUN:  advance = out_free;
            default:
            begin
                load    = 1'b0;
                advance = 1'b0;
            end
        endcase
    end

    assign cmd_pop = load;

    // One step: the remainder gains twice the minor span; reaching twice the
    // span moves the minor coordinate by one cell.
    always_comb
    begin
        step_adv    = step_reg + 1'b1;
        rem_sum     = rem_reg + two_minor_reg;
        minor_moves = rem_sum >= two_span_reg;
        rem_adv     = minor_moves ? (rem_sum - two_span_reg) : rem_sum;
        major_adv   = flags_reg.maj_neg ? (major_reg - 1'b1) : (major_reg + 1'b1);
        if (minor_moves)
        begin
            minor_adv = flags_reg.min_neg ? (minor_reg - 1'b1) : (minor_reg + 1'b1);
        end
        else
        begin
            minor_adv = minor_reg;
        end
        last_adv = step_adv == span_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load || advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg     <= cmd_flags;
            span_reg      <= cmd_span;
            two_minor_reg <= RB'({cmd_minor_span, 1'b0});
            two_span_reg  <= RB'({cmd_span, 1'b0});
            step_reg      <= '0;
            rem_reg       <= RB'(cmd_span);
            major_reg     <= cmd_start_major;
            minor_reg     <= cmd_start_minor;
            if (cmd_flags.too_long)
            begin
                point_x_reg  <= '0;
                point_y_reg  <= '0;
                last_reg     <= 1'b1;
                too_long_reg <= 1'b1;
            end
            else
            begin
                point_x_reg  <= cmd_flags.major_y ? cmd_start_minor : cmd_start_major;
                point_y_reg  <= cmd_flags.major_y ? cmd_start_major : cmd_start_minor;
                last_reg     <= cmd_span == '0;
                too_long_reg <= 1'b0;
            end
        end
        else if (advance)
        begin
            step_reg     <= step_adv;
            rem_reg      <= rem_adv;
            major_reg    <= major_adv;
            minor_reg    <= minor_adv;
            point_x_reg  <= flags_reg.major_y ? minor_adv : major_adv;
            point_y_reg  <= flags_reg.major_y ? major_adv : minor_adv;
            last_reg     <= last_adv;
            too_long_reg <= 1'b0;
        end
    end

endmodule

/* rtl/line_cell_rasterizer.sv */
// The first cell of a line reaches the master side through the queue entry and then the
// back end's output register, when the stepper is idle and no earlier line is queued.
// The stepping back end emits a line of span S as S+1 cells, one cell a cycle while the
// master side takes them; a too-long line gives one result; the stepper sets the rate.
// Reset (rst_n, asynchronous, active low) empties the queue, idles the stepper and
// drops m_tvalid; payload registers are not reset.
// Top level of the line cell rasterizer; uses lcr_pkg, lcr_front, lcr_queue, lcr_back.
`timescale 1ns / 1ps

module line_cell_rasterizer #(
    parameter int COORD_BITS = 10,
    parameter int MAX_STEPS  = 63
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: start_x, start_y, end_x, end_y, zero fill.
    input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0 up: point_x, point_y, zero fill.
    output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // Marks the final cell of a line.
    output logic                                   m_tlast,
    // Field: too_long (the line's span exceeds MAX_STEPS; no cells follow).
    output logic                                   m_tuser
);

    localparam int SB     = lcr_pkg::SPAN_BITS;
    localparam int OUT_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int FLAG_W = $bits(lcr_pkg::line_flags_t);
    // One queue entry: flags, span, minor span, start major, start minor.
    localparam int CMD_W  = FLAG_W + 2 * SB + 2 * COORD_BITS;

    // Unpacked request fields.
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    assign start_x = s_tdata[COORD_BITS-1:0];
    assign start_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign end_x   = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign end_y   = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // Classified line from the front end.
    logic                  push;
    logic                  queue_full;
    lcr_pkg::line_flags_t  front_flags;
    logic [SB-1:0]         front_span;
    logic [SB-1:0]         front_minor_span;
    logic [COORD_BITS-1:0] front_start_major;
    logic [COORD_BITS-1:0] front_start_minor;

    // The front end accepts a request whenever the queue has room, so a new
    // line is taken while the back end is still stepping the previous one.
    lcr_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_STEPS  (MAX_STEPS)
    ) u_front (
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .queue_full  (queue_full),
        .push        (push),
        .flags       (front_flags),
        .span        (front_span),
        .minor_span  (front_minor_span),
        .start_major (front_start_major),
        .start_minor (front_start_minor)
    );

    logic [CMD_W-1:0]      push_data;
    logic [CMD_W-1:0]      pop_data;
    logic                  cmd_pop;
    logic                  cmd_empty;
    lcr_pkg::line_flags_t  cmd_flags;
    logic [SB-1:0]         cmd_span;
    logic [SB-1:0]         cmd_minor_span;
    logic [COORD_BITS-1:0] cmd_start_major;
    logic [COORD_BITS-1:0] cmd_start_minor;

    assign push_data = {front_flags, front_span, front_minor_span,
                        front_start_major, front_start_minor};
    assign {cmd_flags, cmd_span, cmd_minor_span, cmd_start_major, cmd_start_minor} = pop_data;

    // Two entries are enough to hide the hand-over between lines.
    lcr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (cmd_pop),
        .empty     (cmd_empty),
        .pop_data  (pop_data)
    );

    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    // The back end owns the output register; it emits one cell a cycle while
    // the master side takes them, and holds otherwise.
    lcr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_empty       (cmd_empty),
        .cmd_pop         (cmd_pop),
        .cmd_flags       (cmd_flags),
        .cmd_span        (cmd_span),
        .cmd_minor_span  (cmd_minor_span),
        .cmd_start_major (cmd_start_major),
        .cmd_start_minor (cmd_start_minor),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .point_x         (point_x),
        .point_y         (point_y),
        .last            (m_tlast),
        .too_long        (m_tuser)
    );

    // Pack the cell into the data bus, zero filled up to whole bytes.
    assign m_tdata = OUT_W'({point_y, point_x});

endmodule

/* rtl/lcr_checker.sv */
// Port-level checks for the line cell rasterizer, attached by the bind at the end.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module lcr_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                                   m_tlast,
    input logic                                   m_tuser
);

    // A too-long result is marked as the last of its line.
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("too_long result without tlast");

    // The error result carries no cell.
    a_error_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("too_long result with a nonzero cell");

    // A stalled result keeps its contents.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind line_cell_rasterizer lcr_checker #(
    .COORD_BITS (COORD_BITS)
) u_lcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* verif/testbench.sv */
// Self-checking testbench for line_cell_rasterizer: drives endpoint pairs and checks every cell.
// Depends only on rtl/line_cell_rasterizer.sv and the modules it instantiates.
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_BITS = 10;
    localparam int MAX_STEPS  = 63;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int S_WIDTH    = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_WIDTH    = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int RANDOM_LINES  = 310;
    // After this many accepted requests the receiver holds off for a long stretch.
    localparam int HOLD_AFTER    = 120;
    localparam int HOLD_CYCLES   = 400;

    // One cell as it is expected on the master side.
    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  last;
        logic                  too_long;
    } cell_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [S_WIDTH-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [M_WIDTH-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    // Requests still to be offered, and cells still owed by the block, oldest first.
    logic [S_WIDTH-1:0] line_pending[$];
    cell_t              cells_expected[$];

    int lines_accepted = 0;
    int mismatches     = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    bit hold_output    = 1'b0;

    line_cell_rasterizer #(
        .COORD_BITS(COORD_BITS),
        .MAX_STEPS (MAX_STEPS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Packs one request: start_x in the lowest bits, then start_y, end_x, end_y.
    function automatic logic [S_WIDTH-1:0] line_request(int sx, int sy, int ex, int ey);
        logic [S_WIDTH-1:0] req;
        req = '0;
        req[0 +: COORD_BITS]              = COORD_BITS'(sx);
        req[COORD_BITS +: COORD_BITS]     = COORD_BITS'(sy);
        req[2 * COORD_BITS +: COORD_BITS] = COORD_BITS'(ex);
        req[3 * COORD_BITS +: COORD_BITS] = COORD_BITS'(ey);
        return req;
    endfunction

    // Steps away from a start coordinate by an offset; if that leaves the grid,
    // the offset is mirrored, which always fits since offsets stay far below the grid size.
    function automatic int far_end(int s, int d);
        if (s + d > COORD_MAX || s + d < 0)
        begin
            return s - d;
        end
        return s + d;
    endfunction

    // Idle length for either side: mostly none, often a few cycles, now and then a long gap.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(3, 1);
        end
        if (roll < 97)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(30, 15);
    endfunction

    // Random line. Most lines fit within the step limit, with short ones favored so that
    // many lines pass through; some sit right at the limit or one past it and some are
    // fully random endpoint pairs, which nearly always turn out too long.
    function automatic logic [S_WIDTH-1:0] random_line();
        int sx;
        int sy;
        int dmaj;
        int dmin;
        int kind;
        sx   = $urandom_range(COORD_MAX, 0);
        sy   = $urandom_range(COORD_MAX, 0);
        kind = $urandom_range(99, 0);
        if (kind < 10)
        begin
            return line_request(sx, sy, $urandom_range(COORD_MAX, 0),
                                $urandom_range(COORD_MAX, 0));
        end
        if (kind < 16)
        begin
            dmaj = $urandom_range(MAX_STEPS + 1, MAX_STEPS);
        end
        else if (kind < 70)
        begin
            dmaj = $urandom_range(16, 0);
        end
        else
        begin
            dmaj = $urandom_range(MAX_STEPS, 0);
        end
        dmin = $urandom_range(dmaj, 0);
        if ($urandom_range(1, 0) == 1)
        begin
            dmaj = -dmaj;
        end
        if ($urandom_range(1, 0) == 1)
        begin
            dmin = -dmin;
        end
        if ($urandom_range(1, 0) == 1)
        begin
            return line_request(sx, sy, far_end(sx, dmaj), far_end(sy, dmin));
        end
        return line_request(sx, sy, far_end(sx, dmin), far_end(sy, dmaj));
    endfunction

    // Works out every cell that one accepted request must produce and queues them.
    // The longer axis is the major one (x wins ties). At step i the minor offset is
    // round(i * minor / span) with halves rounded away from zero, which in integers
    // is (2 * i * minor + span) / (2 * span) applied to the magnitude.
    function automatic void rasterize_line(input logic [S_WIDTH-1:0] req);
        int sx;
        int sy;
        int ex;
        int ey;
        int adx;
        int ady;
        int span;
        int minor_len;
        int smaj;
        int smin;
        int q;
        bit xneg;
        bit yneg;
        bit major_y;
        bit maj_neg;
        bit min_neg;
        logic [COORD_BITS-1:0] pmaj;
        logic [COORD_BITS-1:0] pmin;
        cell_t want_cell;
        sx = int'(req[0 +: COORD_BITS]);
        sy = int'(req[COORD_BITS +: COORD_BITS]);
        ex = int'(req[2 * COORD_BITS +: COORD_BITS]);
        ey = int'(req[3 * COORD_BITS +: COORD_BITS]);
        xneg      = ex < sx;
        yneg      = ey < sy;
        adx       = xneg ? sx - ex : ex - sx;
        ady       = yneg ? sy - ey : ey - sy;
        major_y   = ady > adx;
        span      = major_y ? ady : adx;
        minor_len = major_y ? adx : ady;
        maj_neg   = major_y ? yneg : xneg;
        min_neg   = major_y ? xneg : yneg;
        smaj      = major_y ? sy : sx;
        smin      = major_y ? sx : sy;
        // A line beyond the step limit gives a single flagged result at the origin.
        if (span > MAX_STEPS)
        begin
            want_cell.point_x  = '0;
            want_cell.point_y  = '0;
            want_cell.last     = 1'b1;
            want_cell.too_long = 1'b1;
            cells_expected.push_back(want_cell);
            return;
        end
        for (int i = 0; i <= span; i++)
        begin
            q    = (span == 0) ? 0 : (2 * i * minor_len + span) / (2 * span);
            pmaj = COORD_BITS'(maj_neg ? smaj - i : smaj + i);
            pmin = COORD_BITS'(min_neg ? smin - q : smin + q);
            want_cell.point_x  = major_y ? pmin : pmaj;
            want_cell.point_y  = major_y ? pmaj : pmin;
            want_cell.last     = (i == span);
            want_cell.too_long = 1'b0;
            cells_expected.push_back(want_cell);
        end
    endfunction

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Request side. A request that is on offer stays put until the block takes it;
    // only then is its expected cells worked out and the next request (or a gap) chosen.
    // Each step assigns s_tvalid once, so valid is never dropped and raised in one step.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                rasterize_line(s_tdata);
                lines_accepted++;
                send_gap = idle_gap();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (line_pending.size() != 0)
            begin
                s_tdata  <= line_pending.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Cell side. Every accepted cell is compared with the oldest expectation, field
    // by field, including the zero fill above point_y. Ready drops for random stalls
    // and for the whole of the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : cell_monitor
        cell_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cells_expected.size() == 0)
                begin
                    report_mismatch($sformatf("cell (%0d,%0d) last=%b too_long=%b with no line owed",
                        m_tdata[0 +: COORD_BITS], m_tdata[COORD_BITS +: COORD_BITS],
                        m_tlast, m_tuser));
                end
                else
                begin
                    want = cells_expected.pop_front();
                    if (m_tdata[0 +: COORD_BITS] !== want.point_x)
                    begin
                        report_mismatch($sformatf("point_x %0d, expected %0d",
                            m_tdata[0 +: COORD_BITS], want.point_x));
                    end
                    if (m_tdata[COORD_BITS +: COORD_BITS] !== want.point_y)
                    begin
                        report_mismatch($sformatf("point_y %0d, expected %0d",
                            m_tdata[COORD_BITS +: COORD_BITS], want.point_y));
                    end
                    if (m_tdata[M_WIDTH-1:2 * COORD_BITS] !== '0)
                    begin
                        report_mismatch($sformatf("tdata fill bits %b are not zero",
                            m_tdata[M_WIDTH-1:2 * COORD_BITS]));
                    end
                    if (m_tlast !== want.last)
                    begin
                        report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
                    end
                    if (m_tuser !== want.too_long)
                    begin
                        report_mismatch($sformatf("too_long %b, expected %b",
                            m_tuser, want.too_long));
                    end
                end
            end
            if (hold_output)
            begin
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // Back pressure: once the run is well under way the receiver stops taking cells
    // for a long stretch while requests keep coming, so the block has to fill up and
    // drop s_tready.
    initial
    begin
        while (lines_accepted < HOLD_AFTER)
        begin
            @(negedge clk);
        end
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
    end

    // Safety limit, far above the slowest legal run.
    initial
    begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        // Directed lines: single cells at both grid corners, the longest legal span in
        // each of the four axis directions, spans just past the limit on either axis and
        // across the whole grid, diagonals in all four directions where x must win the
        // tie, half-way rounding with positive and negative minor steps, lines that start at
        // grid corners, further lines of the longest legal span, and single steps.
        line_pending.push_back(line_request(0, 0, 0, 0));
        line_pending.push_back(line_request(1023, 1023, 1023, 1023));
        line_pending.push_back(line_request(0, 0, 63, 0));
        line_pending.push_back(line_request(1023, 5, 960, 5));
        line_pending.push_back(line_request(7, 0, 7, 63));
        line_pending.push_back(line_request(9, 1023, 9, 960));
        line_pending.push_back(line_request(0, 0, 64, 0));
        line_pending.push_back(line_request(500, 0, 500, 64));
        line_pending.push_back(line_request(0, 0, 1023, 1023));
        line_pending.push_back(line_request(1023, 1023, 0, 0));
        line_pending.push_back(line_request(100, 100, 110, 110));
        line_pending.push_back(line_request(100, 100, 90, 110));
        line_pending.push_back(line_request(100, 100, 110, 90));
        line_pending.push_back(line_request(100, 100, 90, 90));
        line_pending.push_back(line_request(10, 10, 12, 11));
        line_pending.push_back(line_request(10, 10, 12, 9));
        line_pending.push_back(line_request(20, 20, 19, 22));
        line_pending.push_back(line_request(0, 1023, 63, 960));
        line_pending.push_back(line_request(1023, 0, 960, 63));
        line_pending.push_back(line_request(300, 400, 363, 431));
        line_pending.push_back(line_request(5, 5, 6, 5));
        line_pending.push_back(line_request(5, 5, 5, 4));
        line_pending.push_back(line_request(512, 511, 575, 513));
        line_pending.push_back(line_request(0, 0, 1, 63));
        for (int n = 0; n < RANDOM_LINES; n++)
        begin
            line_pending.push_back(random_line());
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request is taken and every owed cell has come out, then give
        // the block a little longer so that any stray extra cell is caught.
        while (line_pending.size() != 0 || s_tvalid || cells_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lcr_pkg.sv
rtl/lcr_front.sv
rtl/lcr_queue.sv
rtl/lcr_back.sv
rtl/line_cell_rasterizer.sv
rtl/lcr_checker.sv
verif/testbench.sv
